// ----- rtl/core/mberm_pkg.sv -----
// Shared types, constants and helpers for the masked bit error rate meter.
// Used by every module under rtl/core; depends on nothing.
package mberm_pkg;

  localparam int MAX_FRAME_DEF = 4096;
  localparam int BITS_PER_BYTE = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 13;
  localparam int TOTAL_W       = 16;
  localparam int RATE_W        = 17;
  localparam int QUO_W         = 32;
  localparam int POP_W         = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CMP_MASK     = 2'd1;

  localparam logic [CFG_DATA_W-1:0] FRAME_LENGTH_RST = 13'd1;
  localparam logic [7:0]            CMP_MASK_RST     = 8'hFF;
  localparam logic [RATE_W-1:0]     RATE_ONE         = 17'h10000;

  typedef struct packed {
    logic [7:0] ref_byte;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] error_count;
    logic [RATE_W-1:0]  error_rate;
    logic               mask_empty;
  } out_item_t;

  typedef struct packed {
    logic               frame_end;
    logic [TOTAL_W-1:0] total;
  } acc_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  function automatic logic [POP_W-1:0] popcount8(input logic [7:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < BITS_PER_BYTE; i++) begin
      n = n + POP_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// ----- rtl/core/masked_bit_error_rate_meter.sv -----
// Masked bit error rate meter: a beat that does not close a frame is taken
// without a stall, and beats may follow back to back. After the beat that closes
// a frame, in_stall stays high while the 32-step restoring divider works out
// count * 65536 / (frame length * mask popcount) and until the result is loaded
// into the output register, which waits while that register is full and stalled;
// with an empty mask the divide is skipped and the result goes straight to it.
// Depends on mberm_pkg, mberm_accum and mberm_divider.
module masked_bit_error_rate_meter #(
  parameter int MAX_FRAME = mberm_pkg::MAX_FRAME_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mberm_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mberm_pkg::out_item_t                out_data,
  input  logic                                cfg_we,
  input  logic [mberm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mberm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int LEN_W = $clog2(MAX_FRAME + 1);
  localparam int DEN_W = LEN_W + mberm_pkg::POP_W;

  logic [mberm_pkg::CFG_DATA_W-1:0] frame_length;
  logic [7:0]                       cmp_mask;

  mberm_pkg::state_t state, state_next;

  logic [LEN_W-1:0]                eff_len;
  logic [mberm_pkg::POP_W-1:0]     mask_bits;
  logic [DEN_W-1:0]                denom;
  logic                            accept;
  logic                            div_start;
  logic                            out_load;
  logic                            div_busy;
  logic                            div_done;
  logic [mberm_pkg::QUO_W-1:0]     quotient;
  mberm_pkg::acc_stat_t            stat;

  logic [mberm_pkg::TOTAL_W-1:0]   count_hold;
  logic                            empty_hold;
  logic [mberm_pkg::RATE_W-1:0]    rate_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= mberm_pkg::FRAME_LENGTH_RST;
      cmp_mask     <= mberm_pkg::CMP_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mberm_pkg::REG_FRAME_LENGTH: frame_length <= cfg_data;
        mberm_pkg::REG_CMP_MASK:     cmp_mask     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(frame_length) > 32'(MAX_FRAME)) begin
      eff_len = LEN_W'(MAX_FRAME);
    end else begin
      eff_len = LEN_W'(frame_length);
    end
    mask_bits = mberm_pkg::popcount8(cmp_mask);
    denom     = DEN_W'(eff_len) * DEN_W'(mask_bits);
  end

  assign accept = in_valid && !in_stall;

  mberm_accum #(
    .MAX_FRAME (MAX_FRAME),
    .LEN_W     (LEN_W)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (in_data),
    .cmp_mask (cmp_mask),
    .eff_len  (eff_len),
    .stat     (stat)
  );

  mberm_divider #(
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({stat.total, 16'h0000}),
    .divisor  (denom),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    case (state)
      mberm_pkg::ST_IDLE: begin
        if (stat.frame_end) begin
          state_next = (mask_bits == '0) ? mberm_pkg::ST_DONE : mberm_pkg::ST_DIV;
        end
      end
      mberm_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = mberm_pkg::ST_DONE;
        end
      end
      mberm_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = mberm_pkg::ST_IDLE;
        end
      end
      default: state_next = mberm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      mberm_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        div_start = stat.frame_end && (mask_bits != '0);
      end
      mberm_pkg::ST_DIV: ;
      mberm_pkg::ST_DONE: begin
        out_load = !out_valid || !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mberm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.frame_end) begin
      count_hold <= stat.total;
      empty_hold <= (mask_bits == '0);
    end
  end

  // mask changed mid-frame can push the quotient past one
  always_comb begin
    if (empty_hold) begin
      rate_sat = '0;
    end else if (quotient > mberm_pkg::QUO_W'(mberm_pkg::RATE_ONE)) begin
      rate_sat = mberm_pkg::RATE_ONE;
    end else begin
      rate_sat = quotient[mberm_pkg::RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.error_count <= count_hold;
      out_data.error_rate  <= rate_sat;
      out_data.mask_empty  <= empty_hold;
    end
  end

`ifndef SYNTHESIS
  a_busy_in_div: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == mberm_pkg::ST_DIV)
    else $error("divider running outside divide state");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    (state == mberm_pkg::ST_DONE && out_valid && out_stall) |=>
      state == mberm_pkg::ST_DONE)
    else $error("result dropped while output beat stalled");

  a_rate_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.error_rate <= mberm_pkg::RATE_ONE)
    else $error("error rate above one");

  a_empty_rate: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.mask_empty) |-> out_data.error_rate == '0)
    else $error("nonzero rate with empty mask");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == mberm_pkg::ST_DIV && in_stall))
    else $error("divide start did not enter divide state");
`endif

endmodule

// ----- rtl/core/mberm_accum.sv -----
// Error accumulator: masked popcount per beat, saturating frame total, pair position.
// Depends on mberm_pkg.
module mberm_accum #(
  parameter int MAX_FRAME = mberm_pkg::MAX_FRAME_DEF,
  parameter int LEN_W     = $clog2(MAX_FRAME + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  mberm_pkg::in_item_t item,
  input  logic [7:0]          cmp_mask,
  input  logic [LEN_W-1:0]    eff_len,
  output mberm_pkg::acc_stat_t stat
);

  localparam int POS_W = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

  logic [mberm_pkg::TOTAL_W-1:0] error_total;
  logic [POS_W-1:0]              pair_position;

  logic [mberm_pkg::POP_W-1:0]   pop;
  logic [mberm_pkg::TOTAL_W:0]   sum;
  logic [mberm_pkg::TOTAL_W-1:0] total_next;
  logic [LEN_W:0]                pos_inc;
  logic                          last_pair;

  always_comb begin
    pop        = mberm_pkg::popcount8((item.ref_byte ^ item.rx_byte) & cmp_mask);
    sum        = {1'b0, error_total} + (mberm_pkg::TOTAL_W + 1)'(pop);
    total_next = sum[mberm_pkg::TOTAL_W] ? '1 : sum[mberm_pkg::TOTAL_W-1:0];
    pos_inc    = (LEN_W + 1)'(pair_position) + 1'b1;
    // length may have shrunk below the position: end on this pair
    last_pair  = !(pos_inc < {1'b0, eff_len});
  end

  assign stat.frame_end = accept && last_pair;
  assign stat.total     = total_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_total   <= '0;
      pair_position <= '0;
    end else if (accept) begin
      if (last_pair) begin
        error_total   <= '0;
        pair_position <= '0;
      end else begin
        error_total   <= total_next;
        pair_position <= POS_W'(pos_inc);
      end
    end
  end

endmodule

// ----- rtl/core/mberm_divider.sv -----
// Restoring divider, one quotient bit per cycle through one shared subtractor.
// Depends on mberm_pkg.
module mberm_divider #(
  parameter int DEN_W = 17
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mberm_pkg::QUO_W-1:0] dividend,
  input  logic [DEN_W-1:0]            divisor,
  output logic                        busy,
  output logic                        done,
  output logic [mberm_pkg::QUO_W-1:0] quotient
);

  localparam int CNT_W = $clog2(mberm_pkg::QUO_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(mberm_pkg::QUO_W - 1);

  logic [DEN_W-1:0]            den;
  logic [DEN_W-1:0]            rem;
  logic [mberm_pkg::QUO_W-1:0] quo;
  logic [CNT_W-1:0]            cnt;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             fits;

  always_comb begin
    rem_sh = {rem, quo[mberm_pkg::QUO_W-1]};
    diff   = rem_sh - {1'b0, den};
    fits   = !diff[DEN_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in from the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo <= {quo[mberm_pkg::QUO_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Testbench for masked_bit_error_rate_meter: table-driven and random byte pairs,
// checked against table values or an in-bench model of the error count and Q1.16 error rate.
// Depends on mberm_pkg and the RTL top; self-contained otherwise.
module tb;

  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PAIRS   = 760;
  localparam int LONG_PAIRS     = 150;
  localparam int TAIL_PAIRS     = 17;
  localparam int DIR_ROWS       = 23;
  localparam int LEN_CLAMP      = mberm_pkg::MAX_FRAME_DEF;

  // unused register slots, written to show they have no effect
  localparam logic [mberm_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [mberm_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    bit          set_cfg;
    logic [12:0] len;
    logic [7:0]  mask;
    logic [7:0]  ref_b;
    logic [7:0]  rx_b;
    bit          typed;
    logic [15:0] count;
    logic [16:0] rate;
    logic        empty;
  } dir_row_t;

  logic                             clk;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_stall;
  mberm_pkg::in_item_t              in_data   = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  mberm_pkg::out_item_t             out_data;
  logic                             cfg_we    = 1'b0;
  logic [mberm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mberm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // model of the block's registers and running frame
  logic [12:0] model_len  = mberm_pkg::FRAME_LENGTH_RST;
  logic [7:0]  model_mask = mberm_pkg::CMP_MASK_RST;
  int unsigned err_total  = 0;
  int unsigned pair_pos   = 0;

  mberm_pkg::out_item_t report_q[$];
  int        fail_count  = 0;
  int        pairs_sent  = 0;
  int        idle_cycles = 0;
  int        stall_left  = 0;
  bit        calm        = 1'b0;

  dir_row_t pair_script [DIR_ROWS] = '{
    // reset settings: length 1, full mask
    '{0, 0,  8'h00, 8'h00, 8'h00, 1, 0,  0,     0},
    '{0, 0,  8'h00, 8'hFF, 8'h00, 1, 8,  65536, 0},
    '{0, 0,  8'h00, 8'h0F, 8'h0E, 1, 1,  8192,  0},
    // length 0 behaves as 1
    '{1, 0,  8'hFF, 8'h80, 8'h00, 1, 1,  8192,  0},
    '{1, 1,  8'h80, 8'h80, 8'h7F, 1, 1,  65536, 0},
    // empty mask: flag set, rate zero
    '{1, 1,  8'h00, 8'hFF, 8'h00, 1, 0,  0,     1},
    '{1, 2,  8'h01, 8'h01, 8'h00, 0, 0,  0,     0},
    '{0, 0,  8'h00, 8'h00, 8'h00, 1, 1,  32768, 0},
    // mask narrowed mid-frame: 18 errors over 4 compared bits, rate clips
    '{1, 4,  8'hFF, 8'hFF, 8'h00, 0, 0,  0,     0},
    '{0, 0,  8'h00, 8'hFF, 8'h00, 0, 0,  0,     0},
    '{1, 4,  8'h01, 8'h01, 8'h00, 0, 0,  0,     0},
    '{0, 0,  8'h00, 8'h01, 8'h00, 1, 18, 65536, 0},
    // five pairs into a 10-pair frame, then length cut to 3
    '{1, 10, 8'hF0, 8'hC3, 8'h3C, 0, 0,  0,     0},
    '{0, 0,  8'h00, 8'h12, 8'h34, 0, 0,  0,     0},
    '{0, 0,  8'h00, 8'hAA, 8'h55, 0, 0,  0,     0},
    '{0, 0,  8'h00, 8'hF0, 8'h0F, 0, 0,  0,     0},
    '{0, 0,  8'h00, 8'h00, 8'hFF, 0, 0,  0,     0},
    '{1, 3,  8'hF0, 8'h99, 8'h66, 0, 0,  0,     0},
    // 5 errors over 15 compared bits: truncated rate
    '{1, 5,  8'h07, 8'h07, 8'h00, 0, 0,  0,     0},
    '{0, 0,  8'h00, 8'h01, 8'h00, 0, 0,  0,     0},
    '{0, 0,  8'h00, 8'h00, 8'h00, 0, 0,  0,     0},
    '{0, 0,  8'h00, 8'h00, 8'h00, 0, 0,  0,     0},
    '{0, 0,  8'h00, 8'h02, 8'h00, 0, 0,  0,     0}
  };

  masked_bit_error_rate_meter u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Adds one pair to the running frame; returns 1 with the report when it closes.
  function automatic bit tally_pair(input mberm_pkg::in_item_t p,
                                    output mberm_pkg::out_item_t r);
    int unsigned       len;
    int unsigned       pop;
    longint unsigned   q;
    len = (model_len == 0) ? 1 : model_len;
    if (len > LEN_CLAMP) len = LEN_CLAMP;
    err_total = err_total + $countones((p.ref_byte ^ p.rx_byte) & model_mask);
    if (err_total > 32'hFFFF) err_total = 32'hFFFF;
    r = '0;
    if (pair_pos + 1 < len) begin
      pair_pos++;
      return 1'b0;
    end
    pop = $countones(model_mask);
    q = 0;
    if (pop != 0) begin
      q = (longint'(err_total) << 16) / (longint'(len) * pop);
      if (q > mberm_pkg::RATE_ONE) q = mberm_pkg::RATE_ONE;
    end
    r.error_count = err_total[15:0];
    r.error_rate  = q[16:0];
    r.mask_empty  = (pop == 0);
    err_total = 0;
    pair_pos  = 0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic mberm_pkg::in_item_t rand_pair();
    mberm_pkg::in_item_t p;
    p.ref_byte = 8'($urandom);
    case ($urandom_range(0, 5))
      0: p.rx_byte = p.ref_byte;
      1: p.rx_byte = ~p.ref_byte;
      2: p.rx_byte = p.ref_byte ^ (8'd1 << $urandom_range(0, 7));
      default: p.rx_byte = 8'($urandom);
    endcase
    return p;
  endfunction

  // Drives one beat and waits for it to be taken; typed rows supply their own report.
  task automatic send_pair(input mberm_pkg::in_item_t p, input int gap,
                           input bit use_typed, input mberm_pkg::out_item_t typed_r);
    mberm_pkg::out_item_t r;
    bit                   closes;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    closes = tally_pair(p, r);
    if (use_typed) report_q.push_back(typed_r);
    else if (closes) report_q.push_back(r);
    pairs_sent++;
  endtask

  // Registers change only once the block has gone quiet.
  task automatic set_config(input logic [12:0] len, input logic [7:0] mask);
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= mberm_pkg::REG_FRAME_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    cfg_index <= mberm_pkg::REG_CMP_MASK;
    cfg_data  <= mberm_pkg::CFG_DATA_W'(mask);
    @(posedge clk);
    cfg_index <= $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
    cfg_data  <= mberm_pkg::CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    model_len  = len;
    model_mask = mask;
  endtask

  initial begin : stimulus
    mberm_pkg::in_item_t  p;
    mberm_pkg::out_item_t w;
    logic [12:0]          len;
    logic [7:0]           mask;
    int                   eff;
    int                   n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (pair_script[i]) begin
      if (pair_script[i].set_cfg) set_config(pair_script[i].len, pair_script[i].mask);
      p.ref_byte    = pair_script[i].ref_b;
      p.rx_byte     = pair_script[i].rx_b;
      w.error_count = pair_script[i].count;
      w.error_rate  = pair_script[i].rate;
      w.mask_empty  = pair_script[i].empty;
      send_pair(p, pick_gap(), pair_script[i].typed, w);
    end

    // random phases; a phase may stop mid-frame, so changes also land mid-frame
    while (pairs_sent < RANDOM_PAIRS + DIR_ROWS) begin
      case ($urandom_range(0, 9))
        0:          len = 13'd0;
        1, 2:       len = 13'd1;
        3, 4, 5, 6: len = 13'($urandom_range(2, 16));
        7:          len = 13'($urandom_range(17, 64));
        8:          len = 13'($urandom_range(65, 300));
        default:    len = 13'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 7))
        0:       mask = 8'h00;
        1, 2:    mask = 8'hFF;
        3:       mask = 8'd1 << $urandom_range(0, 7);
        default: mask = 8'($urandom);
      endcase
      set_config(len, mask);
      calm = ($urandom_range(0, 4) == 0);
      eff  = (len == 0) ? 1 : int'(len);
      n    = $urandom_range(1, 3 * eff + 4);
      if (n > RANDOM_PAIRS + DIR_ROWS - pairs_sent) n = RANDOM_PAIRS + DIR_ROWS - pairs_sent;
      repeat (n) send_pair(rand_pair(), pick_gap(), 1'b0, '0);
    end

    // longest frames: the top of the range and a value past it never close early,
    // then a cut to a short length ends the frame on the next pair
    calm = 1'b0;
    set_config(13'd4096, 8'd1 | 8'($urandom));
    repeat (LONG_PAIRS) send_pair(rand_pair(), pick_gap(), 1'b0, '0);
    set_config(13'h1FFF, 8'hFF);
    repeat (LONG_PAIRS) send_pair(rand_pair(), pick_gap(), 1'b0, '0);
    set_config(13'd2, 8'hFF);
    repeat (TAIL_PAIRS) send_pair(rand_pair(), pick_gap(), 1'b0, '0);

    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // result side: compare each taken beat, then choose the next stall
  always @(posedge clk) begin : result_check
    mberm_pkg::out_item_t want;
    int                   r;
    if (!rst && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        $error("result with none pending: error_count %0d error_rate %0d",
               out_data.error_count, out_data.error_rate);
        fail_count++;
      end else begin
        want = report_q.pop_front();
        if (out_data.error_count !== want.error_count) begin
          $error("error_count: expected %0d, got %0d", want.error_count,
                 out_data.error_count);
          fail_count++;
        end
        if (out_data.error_rate !== want.error_rate) begin
          $error("error_rate: expected %0d, got %0d", want.error_rate,
                 out_data.error_rate);
          fail_count++;
        end
        if (out_data.mask_empty !== want.mask_empty) begin
          $error("mask_empty: expected %0d, got %0d", want.mask_empty,
                 out_data.mask_empty);
          fail_count++;
        end
      end
    end
    r = $urandom_range(0, 99);
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (r < 65) begin
      out_stall <= 1'b0;
    end else if (r < 95) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      stall_left = $urandom_range(10, 40);
      out_stall <= 1'b1;
    end
  end

  // ends a hung run: no beat taken on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
